@@ hw/rtl/lzssd_pkg.sv @@
// Shared types and constants for the LZSS stream decoder.
package lzssd_pkg;

  // Default history window and longest match
  localparam int DEF_HISTORY_DEPTH = 4096;
  localparam int DEF_MAX_MATCH     = 16;

  // Token field widths
  localparam int DIST_W = 12;
  localparam int LEN_W  = 4;

  // Parse position within the compressed stream
  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_MATCH2 = 2'd2
  } phase_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

endpackage

@@ hw/rtl/lzssd_history.sv @@
// History window: byte RAM, write pointer and fill tracking.
module lzssd_history
  import lzssd_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int AW            = $clog2(HISTORY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic [AW-1:0] wr_ptr
);

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] q;
  logic       q_ok;
  logic       wrapped;

  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

  // Write port; pointer wraps at the window size
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      wrapped <= 1'b0;
    end else if (wr_en) begin
      if (wr_ptr == LAST_ADDR) begin
        wr_ptr  <= '0;
        wrapped <= 1'b1;
      end else begin
        wr_ptr <= wr_ptr + AW'(1);
      end
    end
  end

  // Registered read; slots never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q    <= mem[rd_addr];
      q_ok <= wrapped || (rd_addr < wr_ptr);
    end
  end

  assign rd_data = q_ok ? q : 8'd0;

endmodule

@@ hw/rtl/lzss_stream_decoder_core.sv @@
// LZSS stream decoder top level: token parser and match copy sequencer.
//
// Decodes an LZSS stream (8-token flag groups, 12-bit distance, 4-bit length)
// against a history window of HISTORY_DEPTH bytes. in_stall is high whenever the
// sequencer is busy. A flag byte or first match byte is taken without a stall.
// A literal or end marker is taken in ST_IDLE; its result is then held in a
// register and presented in ST_EMIT, through any output stall, until the
// output accepts it. Every copied byte of a match needs its own pass through
// the single read port of the history RAM: it is read in ST_READ, then
// presented and written back in ST_EMIT. History slots not yet written since
// reset read as zero through a fill flag, so no clearing pass is needed.
module lzss_stream_decoder_core
  import lzssd_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int MAX_MATCH     = DEF_MAX_MATCH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       stream_done
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(MAX_MATCH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(HISTORY_DEPTH);

  state_t            state, state_next;
  phase_t            phase;
  logic [7:0]        flag_bits;
  logic [2:0]        token_cnt;
  logic [7:0]        dist_high;
  logic [AW-1:0]     src;
  logic [CNT_W-1:0]  cnt;
  logic [7:0]        lit_byte;
  logic              emit_copy;
  logic              emit_done;

  logic              in_acc, out_acc;
  logic              is_literal;
  logic              hist_wr;
  logic [7:0]        hist_wdata;
  logic [7:0]        rd_data;
  logic [AW-1:0]     wr_ptr;
  logic [DIST_W-1:0] match_dist;
  logic [AW:0]       src_sum;
  logic [AW-1:0]     src_init;
  logic [2:0]        token_inc;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign is_literal = (phase == PH_TOKEN) && !flag_bits[0];
  assign token_inc  = token_cnt + 3'd1;

  // Copy start: (wr_ptr - distance - 1) modulo the window, one compare-subtract
  assign match_dist = {dist_high, in_byte[7:4]};
  assign src_sum    = {1'b0, wr_ptr} + DEPTH_X - (AW + 1)'(match_dist) - (AW + 1)'(1);
  assign src_init   = (src_sum >= DEPTH_X) ? AW'(src_sum - DEPTH_X) : src_sum[AW-1:0];

  // History write: literal at input accept, copied byte at output accept
  assign hist_wr    = (in_acc && is_literal) || (out_acc && emit_copy);
  assign hist_wdata = emit_copy ? rd_data : in_byte;

  lzssd_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .AW           (AW)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (hist_wr),
    .wr_data(hist_wdata),
    .rd_en  (state == ST_READ),
    .rd_addr(src),
    .rd_data(rd_data),
    .wr_ptr (wr_ptr)
  );

  // Result fields
  assign out_byte    = emit_done ? 8'd0 : (emit_copy ? rd_data : lit_byte);
  assign last_of_run = emit_copy ? (cnt == '0) : 1'b1;
  assign stream_done = emit_done;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_literal) begin
            state_next = ST_EMIT;
          end else if (phase == PH_MATCH2) begin
            state_next = (in_byte[3:0] == '0) ? ST_EMIT : ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          state_next = (emit_copy && (cnt != '0)) ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Parser and copy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FLAG;
      flag_bits <= 8'd0;
      token_cnt <= 3'd0;
      dist_high <= 8'd0;
      emit_copy <= 1'b0;
      emit_done <= 1'b0;
    end else begin
      if (in_acc) begin
        case (phase)
          PH_TOKEN: begin
            if (!flag_bits[0]) begin
              lit_byte  <= in_byte;
              emit_copy <= 1'b0;
              emit_done <= 1'b0;
              flag_bits <= flag_bits >> 1;
              token_cnt <= token_inc;
              phase     <= (token_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
            end else begin
              dist_high <= in_byte;
              phase     <= PH_MATCH2;
            end
          end
          PH_MATCH2: begin
            if (in_byte[3:0] == '0) begin
              // end marker
              emit_copy <= 1'b0;
              emit_done <= 1'b1;
              flag_bits <= 8'd0;
              token_cnt <= 3'd0;
              phase     <= PH_FLAG;
            end else begin
              emit_copy <= 1'b1;
              emit_done <= 1'b0;
              src       <= src_init;
              cnt       <= CNT_W'(in_byte[3:0]);
            end
          end
          default: begin
            flag_bits <= in_byte;
            token_cnt <= 3'd0;
            phase     <= PH_TOKEN;
          end
        endcase
      end
      // Advance the copy on each delivered byte
      if (out_acc && emit_copy) begin
        if (cnt == '0) begin
          emit_copy <= 1'b0;
          flag_bits <= flag_bits >> 1;
          token_cnt <= token_inc;
          phase     <= (token_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
        end else begin
          cnt <= cnt - CNT_W'(1);
          src <= (src == LAST_ADDR) ? '0 : src + AW'(1);
        end
      end
    end
  end

  // Checks
  a_busy_while_out : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_done_is_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_done) |-> (last_of_run && !emit_copy))
    else $error("end marker result not marked last");

  a_literal_emits : assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_literal) |=> (out_valid && !emit_copy && !stream_done))
    else $error("literal did not produce a result");

  a_copy_via_read : assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (out_valid && emit_copy))
    else $error("history read not followed by copy output");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the LZSS stream decoder core.
`timescale 1ns / 1ps

import lzssd_pkg::*;

// One decoded output item as the block should present it
typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       done;
} decoded_t;

// Shadow decoder: tracks parse state and history, queues the bytes each item should produce
class lzss_window_board;
  phase_t      phase;
  logic [7:0]  flags;
  logic [2:0]  tok_cnt;
  logic [7:0]  dist_hi;
  logic [7:0]  window [DEF_HISTORY_DEPTH];
  int unsigned wr_ptr;
  decoded_t    due_bytes [$];
  int          errors;

  function new();
    phase   = PH_FLAG;
    flags   = '0;
    tok_cnt = '0;
    dist_hi = '0;
    wr_ptr  = 0;
    errors  = 0;
    foreach (window[i]) window[i] = '0;
  endfunction

  // write one byte to the history and queue it as an output
  function void emit(logic [7:0] b, logic last);
    decoded_t d;
    window[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % DEF_HISTORY_DEPTH;
    d.data = b;
    d.last = last;
    d.done = 1'b0;
    due_bytes.push_back(d);
  endfunction

  function void next_token();
    flags   = flags >> 1;
    tok_cnt = tok_cnt + 3'd1;
    phase   = (tok_cnt == 3'd0) ? PH_FLAG : PH_TOKEN;
  endfunction

  // note one accepted input byte
  function void absorb_byte(logic [7:0] b);
    int unsigned match_dist;
    int unsigned len;
    int unsigned src;
    decoded_t    d;
    case (phase)
      PH_TOKEN: begin
        if (!flags[0]) begin
          emit(b, 1'b1);
          next_token();
        end else begin
          dist_hi = b;
          phase   = PH_MATCH2;
        end
      end
      PH_MATCH2: begin
        match_dist = 32'({dist_hi, b[7:4]});
        len        = 32'(b[3:0]) + 1;
        if (b[3:0] == 4'h0) begin
          // end marker: group restarts, history is kept
          d.data = 8'h00;
          d.last = 1'b1;
          d.done = 1'b1;
          due_bytes.push_back(d);
          flags   = '0;
          tok_cnt = '0;
          phase   = PH_FLAG;
        end else begin
          src = (wr_ptr + DEF_HISTORY_DEPTH - match_dist - 1) % DEF_HISTORY_DEPTH;
          for (int i = 0; i < len; i++) begin
            emit(window[src], (i + 1 == len));
            src = (src + 1) % DEF_HISTORY_DEPTH;
          end
          next_token();
        end
      end
      default: begin
        flags   = b;
        tok_cnt = '0;
        phase   = PH_TOKEN;
      end
    endcase
  endfunction

  // compare one accepted output item with the oldest queued one
  function void check_result(logic [7:0] data, logic last, logic done);
    decoded_t d;
    if (due_bytes.size() == 0) begin
      $display("%0t: unexpected output item byte %02h last %0b done %0b",
               $time, data, last, done);
      errors++;
      return;
    end
    d = due_bytes.pop_front();
    if (done !== d.done) begin
      $display("%0t: stream_done expected %0b got %0b", $time, d.done, done);
      errors++;
    end
    if (last !== d.last) begin
      $display("%0t: last_of_run expected %0b got %0b", $time, d.last, last);
      errors++;
    end
    // byte is don't-care on the completion item
    if (!d.done && data !== d.data) begin
      $display("%0t: out_byte expected %02h got %02h", $time, d.data, data);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  lzss_window_board board;
  logic [7:0] stim [$];
  int         burst_left;
  int         items_sent;
  logic       hold_req;

  lzss_stream_decoder_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one item, in bursts with random gaps; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    board.absorb_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (stim.size() != 0) send_byte(stim.pop_front());
  endtask

  // stop offering until every queued output has come out
  task automatic drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (board.due_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // well-formed stream of n tokens closed by an end marker; unused flag bits random
  task automatic queue_stream(input int n_tokens, input int match_pct);
    int          tok;
    logic [7:0]  flag;
    logic [7:0]  body [$];
    logic [11:0] dm1;
    logic [3:0]  lm1;
    tok = 0;
    while (tok <= n_tokens) begin
      flag = 8'($urandom);
      body = {};
      for (int k = 0; k < 8 && tok <= n_tokens; k++) begin
        if (tok == n_tokens) begin
          flag[k] = 1'b1;
          dm1 = 12'($urandom);
          body.push_back(dm1[11:4]);
          body.push_back({dm1[3:0], 4'h0});
        end else if ($urandom_range(99) < match_pct) begin
          flag[k] = 1'b1;
          // mostly short reach, sometimes anywhere in the window
          dm1 = 12'(($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(31));
          lm1 = 4'($urandom_range(15, 1));
          body.push_back(dm1[11:4]);
          body.push_back({dm1[3:0], lm1});
        end else begin
          flag[k] = 1'b0;
          body.push_back(8'($urandom));
        end
        tok++;
      end
      stim.push_back(flag);
      foreach (body[i]) stim.push_back(body[i]);
    end
  endtask

  // output side: random stall pattern, plus one long hold-off on request
  initial begin : rx_pattern
    int stall_pct;
    int hold_left;
    int cyc;
    bit hold_taken;
    stall_pct = 0;
    hold_left = 0;
    cyc = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        if (cyc % 64 == 0) begin
          case ($urandom_range(4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 55;
            default: stall_pct = 85;
          endcase
        end
        out_stall = ($urandom_range(99) < stall_pct);
      end
      cyc++;
    end
  end

  // sample outputs
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(out_byte, last_of_run, stream_done);
    end
  end

  // main sequence
  initial begin : main_seq
    // eight literals, a full-length match reaching before stream start, an
    // overlapping run, a shortest match, end marker; then a stream reading back
    // into the previous one with an end marker in mid group
    logic [7:0] directed_bytes [24] = '{
      8'h00, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h0F, 8'h00, 8'h21, 8'h00, 8'h00,
      8'h05, 8'h01, 8'h34, 8'h5A, 8'hAB, 8'hC0
    };
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    hold_req = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain();

    // long output hold-off while match-heavy input keeps coming
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    queue_stream(12, 70);
    send_queued();
    drain();

    // random well-formed streams
    while (items_sent < 250) begin
      queue_stream($urandom_range(14, 2), $urandom_range(90, 10));
      send_queued();
      if ($urandom_range(4) == 0) drain();
    end

    // unframed noise
    repeat (30) send_byte(8'($urandom));
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS lzss_stream_decoder_core");
    end else begin
      $display("FAIL lzss_stream_decoder_core");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2ms;
    $display("FAIL lzss_stream_decoder_core");
    $finish;
  end

endmodule
